// ===== sv/l2u_pkg.sv =====
// Shared types and constants for the Latin-1 / UTF-8 transcoder.
// Used by every module of the block; depends on nothing else.
package l2u_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;
    localparam int ADDR_W     = 3;

    localparam logic [1:0] MODE_COPY      = 2'd0;
    localparam logic [1:0] MODE_TO_UTF8   = 2'd1;
    localparam logic [1:0] MODE_TO_LATIN1 = 2'd2;

    localparam logic [ADDR_W-1:0] ADDR_MODE = 3'd0;

    localparam logic [7:0] QMARK      = 8'h3F;
    localparam logic [7:0] LEAD2_BASE = 8'hC0;
    localparam logic [7:0] CONT_BASE  = 8'h80;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       replaced;
        logic       item_done;
        logic       string_end;
        logic       string_lossy;
    } out_item_t;

    typedef struct packed {
        logic       lead_pending;
        logic [4:0] lead_bits;
        logic       skipping;
        logic       lossy;
    } dec_state_t;

endpackage

// ===== sv/l2u_regs.sv =====
// APB-style configuration register file holding the transcoding mode.
// Depends on l2u_pkg for the address width and register addresses.
module l2u_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [l2u_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [1:0]                 mode
);
    import l2u_pkg::*;

    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        mode_next = mode_reg;
        if (wr_en && (paddr == ADDR_MODE))
        begin
            mode_next = pwdata[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_COPY;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr == ADDR_MODE)
        begin
            prdata = {30'd0, mode_reg};
        end
    end

    assign mode = mode_reg;

endmodule

// ===== sv/l2u_decode.sv =====
// Per-byte conversion logic and the decoder state it carries between bytes.
// Depends on l2u_pkg for the item and state types and the mode codes.
module l2u_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic [1:0]         mode,
    input  l2u_pkg::in_item_t  item,
    output logic [1:0]         res_cnt,
    output l2u_pkg::out_item_t res0,
    output l2u_pkg::out_item_t res1
);
    import l2u_pkg::*;

    dec_state_t st_reg;
    dec_state_t st_next;
    logic [7:0] b;
    logic       last;
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;

    assign b    = item.in_byte;
    assign last = item.string_last;

    always_comb
    begin
        st_next = st_reg;
        n       = 2'd0;
        r0      = '0;
        r1      = '0;
        unique case (mode)
            MODE_TO_UTF8:
            begin
                st_next.lead_pending = 1'b0;
                st_next.skipping     = 1'b0;
                if (!b[7])
                begin
                    r0.out_byte   = b;
                    r0.byte_valid = 1'b1;
                    n             = 2'd1;
                end
                else
                begin
                    r0.out_byte   = LEAD2_BASE | {6'd0, b[7:6]};
                    r0.byte_valid = 1'b1;
                    r1.out_byte   = CONT_BASE | {2'd0, b[5:0]};
                    r1.byte_valid = 1'b1;
                    n             = 2'd2;
                end
            end
            MODE_TO_LATIN1:
            begin
                if (st_reg.lead_pending)
                begin
                    st_next.lead_pending = 1'b0;
                    r0.byte_valid        = 1'b1;
                    n                    = 2'd1;
                    if (st_reg.lead_bits[4:2] == 3'd0)
                    begin
                        r0.out_byte = {st_reg.lead_bits[1:0], b[5:0]};
                    end
                    else
                    begin
                        r0.out_byte   = QMARK;
                        r0.replaced   = 1'b1;
                        st_next.lossy = 1'b1;
                    end
                end
                else if (st_reg.skipping && (b[7:6] == 2'b10))
                begin
                    n = 2'd0;
                end
                else
                begin
                    st_next.skipping = 1'b0;
                    if (!b[7])
                    begin
                        r0.out_byte   = b;
                        r0.byte_valid = 1'b1;
                        n             = 2'd1;
                    end
                    else if ((b[7:5] == 3'b110) && !last)
                    begin
                        st_next.lead_pending = 1'b1;
                        st_next.lead_bits    = b[4:0];
                    end
                    else
                    begin
                        r0.out_byte      = QMARK;
                        r0.byte_valid    = 1'b1;
                        r0.replaced      = 1'b1;
                        n                = 2'd1;
                        st_next.lossy    = 1'b1;
                        st_next.skipping = 1'b1;
                    end
                end
            end
            default:
            begin
                st_next.lead_pending = 1'b0;
                st_next.skipping     = 1'b0;
                r0.out_byte          = b;
                r0.byte_valid        = 1'b1;
                n                    = 2'd1;
            end
        endcase

        if (last)
        begin
            if (n == 2'd0)
            begin
                n = 2'd1;
            end
            if (n == 2'd2)
            begin
                r1.string_end   = 1'b1;
                r1.string_lossy = st_next.lossy;
            end
            else
            begin
                r0.string_end   = 1'b1;
                r0.string_lossy = st_next.lossy;
            end
            st_next.lead_pending = 1'b0;
            st_next.skipping     = 1'b0;
            st_next.lossy        = 1'b0;
        end

        if (n == 2'd2)
        begin
            r1.item_done = 1'b1;
        end
        else if (n == 2'd1)
        begin
            r0.item_done = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

    assign res_cnt = n;
    assign res0    = r0;
    assign res1    = r1;

endmodule

// ===== sv/l2u_out_fifo.sv =====
// Small result queue that takes up to two results per cycle and gives one.
// Depends on l2u_pkg for the result type and the queue dimensions.
module l2u_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         push_cnt,
    input  l2u_pkg::out_item_t push0,
    input  l2u_pkg::out_item_t push1,
    output logic               space_ok,
    output logic               out_valid,
    input  logic               out_ready,
    output l2u_pkg::out_item_t out_data
);
    import l2u_pkg::*;

    out_item_t        entries_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] after_pop;
    logic             pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = entries_reg[rd_ptr_reg];
    assign after_pop = count_reg - {{(CNT_W-1){1'b0}}, pop};
    assign space_ok  = (after_pop <= CNT_W'(FIFO_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + {{(PTR_W-1){1'b0}}, pop};
    assign count_next  = after_pop + {{(CNT_W-2){1'b0}}, push_cnt};

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            entries_reg[wr_ptr_reg + PTR_W'(1)] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue count exceeds its depth");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != 2'd0) |-> space_ok)
        else $error("results pushed without room in the queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == 2'd0) && !pop |=> $stable(count_reg) && $stable(wr_ptr_reg))
        else $error("queue count moved without a push or pop");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("queue empty but pointers differ");
`endif

endmodule

// ===== sv/latin1_utf8_transcoder_top.sv =====
// Top level of the Latin-1 / UTF-8 transcoder: input stage, decoder and result queue.
// Depends on l2u_pkg, l2u_regs, l2u_decode and l2u_out_fifo.
//
// The block converts a byte stream one byte per transfer, copying it, widening Latin-1
// to UTF-8 or narrowing UTF-8 to Latin-1 as the mode register selects. A byte enters an
// input register, is converted from there by the decoder and its zero, one or two results
// are written into a four-entry result queue, which offers them one at a time at the output.
// A converted byte moves into the queue only while two entries are free, so a stalled
// output holds the input. The single output port delivers one result per cycle while
// out_ready is high, so copy mode and bytes below 0x80 sustain one byte per cycle, while
// Latin-1 bytes of 0x80 and above give two results each when widened. Every string ends
// with a result marked string_end.
module latin1_utf8_transcoder_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [l2u_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  l2u_pkg::in_item_t          in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output l2u_pkg::out_item_t         out_data
);
    import l2u_pkg::*;

    logic       stage_valid_reg;
    logic       stage_valid_next;
    in_item_t   stage_item_reg;
    logic       stage_fire;
    logic       space_ok;
    logic [1:0] mode;
    logic [1:0] res_cnt;
    logic [1:0] push_cnt;
    out_item_t  res0;
    out_item_t  res1;

    l2u_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mode    (mode)
    );

    assign stage_fire       = stage_valid_reg && space_ok;
    assign in_ready         = !stage_valid_reg || stage_fire;
    assign stage_valid_next = (in_valid && in_ready) || (stage_valid_reg && !stage_fire);
    assign push_cnt         = stage_fire ? res_cnt : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_item_reg <= in_data;
        end
    end

    l2u_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (stage_fire),
        .mode    (mode),
        .item    (stage_item_reg),
        .res_cnt (res_cnt),
        .res0    (res0),
        .res1    (res1)
    );

    l2u_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
